### hw/rtl/jgt_pkg.sv
// ----------------------------------------------------------------------------
// Joint global transform package
// Shared widths, defaults and field layout for the joint transform core.
// ----------------------------------------------------------------------------
package jgt_pkg;

	localparam int MaxJointsDef = 256;
	localparam int DataWidthDef = 32;

	// input request: parent_index (9), then trans_x..z, rot_w..z, scale_x..z,
	// 32 bits each -> 9+320 = 329, pad to 336
	localparam int InDataW  = 336;
	// result: joint_index, row_index, elem_col0..3 -> 8+2+128 = 138, pad to 144
	localparam int OutDataW = 144;
	// slave tuser: first_joint
	localparam int InUserW  = 1;

endpackage

### hw/rtl/joint_global_transform_core.sv
// ----------------------------------------------------------------------------
// Joint global transform core
// Skeletal forward kinematics: local T*R*S per joint, chained to the parent.
// ----------------------------------------------------------------------------
// One joint request is taken per pass. A single 32x32 signed multiplier,
// registered at its output, does every product in turn: nine quaternion
// products, nine rotation-by-scale products and, for a child joint, 36
// parent-by-local products (three per element, the translation column
// included). The multiplier sequence, the twelve store writes and the three
// output rows set the length of a pass, which grows while a row waits on
// m_tready. The row store holds MAX_JOINTS*12 elements in one memory with
// one write and one registered read port; it is never cleared, since a parent
// is always written earlier in the same pose. Requests beyond MAX_JOINTS are
// dropped without result. The block takes no new request until the last row
// of the current one has been taken.
// ----------------------------------------------------------------------------
module joint_global_transform_core #(
	parameter int MAX_JOINTS = jgt_pkg::MaxJointsDef,
	parameter int DATA_WIDTH = jgt_pkg::DataWidthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// parent_index, trans_x, trans_y, trans_z, rot_w, rot_x, rot_y, rot_z,
	// scale_x, scale_y, scale_z, zero pad
	input  logic [jgt_pkg::InDataW-1:0]  s_tdata,
	// first_joint
	input  logic [jgt_pkg::InUserW-1:0]  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// joint_index, row_index, elem_col0, elem_col1, elem_col2, elem_col3, zero pad
	output logic [jgt_pkg::OutDataW-1:0] m_tdata,
	// last_row
	output logic                        m_tlast
);
	import jgt_pkg::*;

	localparam int EB  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int CW  = $clog2(MAX_JOINTS + 1);
	localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int AW  = $clog2(MAX_JOINTS * 12);
	localparam int PW  = (CW > 8) ? CW : 8;
	localparam logic signed [63:0] SatHi = (64'sd1 <<< (EB - 1)) - 64'sd1;
	localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_QUAT, ST_LOCAL, ST_PREAD, ST_CHAIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [JW-1:0] idx_q;
	logic [8:0] par_q;
	logic has_par_q;
	logic signed [31:0] t_q [3];
	logic signed [31:0] s_q [3];
	logic signed [31:0] qv_q [4];
	logic signed [33:0] qp_q [9];   // xx yy zz xy xz yz wx wy wz
	logic signed [31:0] l_q [12];
	logic signed [31:0] g_q [12];
	logic signed [31:0] p_q [12];
	logic signed [63:0] acc_q;
	logic [5:0] step_q;
	logic [1:0] ri_q, ci_q, ki_q;   // row, column, inner index of the issued product
	logic       mv_q;               // product register holds a result
	logic [3:0] mstep_q;
	logic [1:0] mi_q, mc_q, mk_q;   // indexes of the product in prod_q
	logic signed [63:0] prod_q;
	logic [1:0] row_q;

	logic signed [31:0] mem [MAX_JOINTS*12];
	logic signed [31:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic [3:0] rd_k_q;
	logic rd_v_q;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [3:0] wr_sel;

	function automatic logic signed [63:0] sat_f(input logic signed [63:0] v);
		if (v > SatHi) return SatHi;
		if (v < SatLo) return SatLo;
		return v;
	endfunction

	// rotation element in Q.30 from the quaternion products
	function automatic logic signed [63:0] rot_f(input logic [3:0] e,
		input logic signed [33:0] q [9]);
		logic signed [63:0] one, a, b;
		one = 64'sd1 <<< 30;
		a = 64'(q[0]); b = 64'(q[1]);
		case (e)
			4'd0: rot_f = one - 2 * (64'(q[1]) + 64'(q[2]));
			4'd1: rot_f = 2 * (64'(q[3]) - 64'(q[8]));
			4'd2: rot_f = 2 * (64'(q[4]) + 64'(q[7]));
			4'd3: rot_f = 2 * (64'(q[3]) + 64'(q[8]));
			4'd4: rot_f = one - 2 * (a + 64'(q[2]));
			4'd5: rot_f = 2 * (64'(q[5]) - 64'(q[6]));
			4'd6: rot_f = 2 * (64'(q[4]) - 64'(q[7]));
			4'd7: rot_f = 2 * (64'(q[5]) + 64'(q[6]));
			default: rot_f = one - 2 * (a + b);
		endcase
	endfunction

	// select multiplier operands for the current step
	logic signed [31:0] op_a, op_b;
	logic mul_go;
	always_comb begin
		op_a = '0; op_b = '0; mul_go = 1'b0;
		case (state_q)
			ST_QUAT: begin
				mul_go = step_q < 6'd9;
				case (step_q)
					6'd0: begin op_a = qv_q[1]; op_b = qv_q[1]; end
					6'd1: begin op_a = qv_q[2]; op_b = qv_q[2]; end
					6'd2: begin op_a = qv_q[3]; op_b = qv_q[3]; end
					6'd3: begin op_a = qv_q[1]; op_b = qv_q[2]; end
					6'd4: begin op_a = qv_q[1]; op_b = qv_q[3]; end
					6'd5: begin op_a = qv_q[2]; op_b = qv_q[3]; end
					6'd6: begin op_a = qv_q[0]; op_b = qv_q[1]; end
					6'd7: begin op_a = qv_q[0]; op_b = qv_q[2]; end
					default: begin op_a = qv_q[0]; op_b = qv_q[3]; end
				endcase
			end
			ST_LOCAL: begin
				mul_go = step_q < 6'd9;
				op_a = 32'(rot_f(step_q[3:0], qp_q) >>> 14);
				op_b = s_q[ci_q];
			end
			ST_CHAIN: begin
				// issue order: row, then column, then inner index
				mul_go = step_q < 6'd36;
				op_a = p_q[{ri_q, ki_q}];
				op_b = l_q[{ki_q, ci_q}];
			end
			default: ;
		endcase
	end

	assign rd_en = (state_q == ST_PREAD) && (step_q < 6'd12);
	assign rd_addr = AW'(par_q[7:0]) * AW'(12) + AW'(step_q[3:0]);

	// write the finished rows into the store before they are handed out
	assign wr_en = (state_q == ST_OUT) && (step_q < 6'd12);
	assign wr_sel = step_q[3:0];
	assign wr_addr = AW'(idx_q) * AW'(12) + AW'(step_q[3:0]);

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= g_q[wr_sel];
	end

	logic s_hs, m_hs;
	assign s_hs = s_tvalid && s_tready;
	assign m_hs = m_tvalid && m_tready;
	assign s_tready = (state_q == ST_IDLE);

	logic [CW-1:0] cnt_eff;
	assign cnt_eff = s_tuser[0] ? '0 : cnt_q;

	logic signed [63:0] fl16, chain_sum;
	assign fl16 = prod_q >>> 16;

	// running dot product; the translation column starts from the parent offset
	always_comb begin
		chain_sum = acc_q + fl16;
		if (mk_q == 2'd0)
			chain_sum = (mc_q == 2'd3) ? 64'(p_q[{mi_q, 2'd3}]) + fl16 : fl16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			step_q <= '0;
			mv_q <= 1'b0;
			rd_v_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// shared multiplier, one product per cycle
			mv_q <= mul_go;
			mstep_q <= step_q[3:0];
			mi_q <= ri_q;
			mc_q <= ci_q;
			mk_q <= ki_q;
			prod_q <= op_a * op_b;
			rd_v_q <= rd_en;
			rd_k_q <= step_q[3:0];
			if (rd_v_q) p_q[rd_k_q] <= rd_q;
			case (state_q)
				ST_IDLE: begin
					if (s_hs) begin
						cnt_q <= cnt_eff;
						if (cnt_eff < CW'(MAX_JOINTS)) begin
							idx_q <= JW'(cnt_eff);
							par_q <= s_tdata[8:0];
							has_par_q <= !s_tdata[8] && (PW'(s_tdata[7:0]) < PW'(cnt_eff));
							for (int i = 0; i < 3; i++) begin
								t_q[i] <= s_tdata[9 + 32*i +: 32];
								s_q[i] <= s_tdata[9 + 32*(7+i) +: 32];
							end
							for (int i = 0; i < 4; i++) qv_q[i] <= s_tdata[9 + 32*(3+i) +: 32];
							step_q <= '0;
							state_q <= ST_QUAT;
						end
					end
				end
				ST_QUAT: begin
					// hold for the last product to land
					if (mv_q) qp_q[mstep_q] <= 34'(prod_q >>> 30);
					if (step_q == 6'd9) begin
						step_q <= '0;
						ri_q <= '0;
						ci_q <= '0;
						ki_q <= '0;
						state_q <= ST_LOCAL;
					end else step_q <= step_q + 6'd1;
				end
				ST_LOCAL: begin
					// a root's global matrix is its local one: fill both
					if (mv_q) begin
						l_q[{mi_q, mc_q}] <= 32'(sat_f(fl16));
						g_q[{mi_q, mc_q}] <= 32'(sat_f(fl16));
					end
					if (step_q == 6'd9) begin
						for (int i = 0; i < 3; i++) begin
							l_q[{2'(i), 2'd3}] <= 32'(sat_f(64'(t_q[i])));
							g_q[{2'(i), 2'd3}] <= 32'(sat_f(64'(t_q[i])));
						end
						step_q <= '0;
						ri_q <= '0;
						ci_q <= '0;
						ki_q <= '0;
						state_q <= has_par_q ? ST_PREAD : ST_OUT;
					end else begin
						step_q <= step_q + 6'd1;
						if (ci_q == 2'd2) begin
							ci_q <= '0;
							ri_q <= ri_q + 2'd1;
						end else ci_q <= ci_q + 2'd1;
					end
				end
				ST_PREAD: begin
					if (step_q == 6'd13) begin
						step_q <= '0;
						acc_q <= '0;
						state_q <= ST_CHAIN;
					end else step_q <= step_q + 6'd1;
				end
				ST_CHAIN: begin
					if (mv_q) begin
						if (mk_q == 2'd2) g_q[{mi_q, mc_q}] <= 32'(sat_f(chain_sum));
						else acc_q <= chain_sum;
					end
					if (step_q == 6'd36) begin
						step_q <= '0;
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 6'd1;
						if (ki_q == 2'd2) begin
							ki_q <= '0;
							if (ci_q == 2'd3) begin
								ci_q <= '0;
								ri_q <= ri_q + 2'd1;
							end else ci_q <= ci_q + 2'd1;
						end else ki_q <= ki_q + 2'd1;
					end
				end
				ST_OUT: begin
					if (step_q < 6'd12) step_q <= step_q + 6'd1;
					if (step_q == 6'd12 && !m_tvalid) begin
						m_tvalid <= 1'b1;
						row_q <= 2'd0;
						step_q <= 6'd13;
					end
					if (m_hs) begin
						if (row_q == 2'd2) begin
							m_tvalid <= 1'b0;
							cnt_q <= cnt_q + CW'(1);
							state_q <= ST_IDLE;
						end else row_q <= row_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// present the current row
	logic signed [31:0] row_e [4];
	always_comb begin
		for (int c = 0; c < 4; c++) row_e[c] = g_q[{row_q, 2'(c)}];
		m_tdata = '0;
		m_tdata[7:0] = 8'(idx_q);
		m_tdata[9:8] = row_q;
		for (int c = 0; c < 4; c++) m_tdata[10 + 32*c +: 32] = row_e[c];
		m_tlast = (row_q == 2'd2);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_q == ST_OUT) else $error("result outside output phase");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken while rows pending");
	a_row_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> row_q != 2'd3) else $error("row number out of range");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joint global transform core testbench
// Drives joint requests in bursts, predicts the three global matrix rows of
// each joint and checks every emitted row in order against the prediction.
// ----------------------------------------------------------------------------
module tb_top;

	import jgt_pkg::*;

	localparam int NumJoints = MaxJointsDef;
	localparam int RandItems = 106;
	localparam longint ElemHi = 64'sd2147483647;
	localparam longint ElemLo = -64'sd2147483648;
	localparam logic signed [31:0] QOne = 32'sh4000_0000;
	localparam logic signed [31:0] FxOne = 32'sh0001_0000;
	localparam logic signed [31:0] SMax = 32'sh7fff_ffff;
	localparam logic signed [31:0] SMin = 32'sh8000_0000;

	typedef struct packed {
		logic              first_joint;
		logic signed [8:0] parent_index;
		logic signed [31:0] trans_x, trans_y, trans_z;
		logic signed [31:0] rot_w, rot_x, rot_y, rot_z;
		logic signed [31:0] scale_x, scale_y, scale_z;
	} joint_req_t;

	typedef struct packed {
		logic [7:0]         joint_index;
		logic [1:0]         row_index;
		logic signed [31:0] col0, col1, col2, col3;
		logic               last_row;
	} row_res_t;

	// directed row: request plus an optional hand-typed row 0
	typedef struct {
		joint_req_t req;
		bit         typed;
		row_res_t   row0;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic [InUserW-1:0]  s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tlast;

	joint_global_transform_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// predictor state
	logic signed [31:0] pose_rows [NumJoints*12];
	int unsigned        joint_count;
	row_res_t           row_queue[$];
	int                 mismatches;
	int                 unmatched;
	bit                 stim_done;
	bit                 hold_long;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > ElemHi) begin
			return ElemHi;
		end
		if (v < ElemLo) begin
			return ElemLo;
		end
		return v;
	endfunction

	function automatic longint qprod(longint a, longint b);
		return floor_shr(a * b, 30);
	endfunction

	// compute the global rows of one joint, update the pose store, queue rows
	task automatic predict_joint(input joint_req_t q);
		longint w, x, y, z, one, acc;
		longint rm [3][3];
		longint lm [3][4];
		longint gm [3][4];
		longint sc [3];
		longint tr [3];
		int unsigned idx;
		row_res_t r;
		bit has_parent;
		if (q.first_joint) begin
			joint_count = 0;
		end
		if (joint_count >= NumJoints) begin
			return;
		end
		idx = joint_count;
		w = q.rot_w; x = q.rot_x; y = q.rot_y; z = q.rot_z;
		sc[0] = q.scale_x; sc[1] = q.scale_y; sc[2] = q.scale_z;
		tr[0] = q.trans_x; tr[1] = q.trans_y; tr[2] = q.trans_z;
		one = 64'sd1 << 30;
		rm[0][0] = one - 2 * (qprod(y, y) + qprod(z, z));
		rm[0][1] = 2 * (qprod(x, y) - qprod(w, z));
		rm[0][2] = 2 * (qprod(x, z) + qprod(w, y));
		rm[1][0] = 2 * (qprod(x, y) + qprod(w, z));
		rm[1][1] = one - 2 * (qprod(x, x) + qprod(z, z));
		rm[1][2] = 2 * (qprod(y, z) - qprod(w, x));
		rm[2][0] = 2 * (qprod(x, z) - qprod(w, y));
		rm[2][1] = 2 * (qprod(y, z) + qprod(w, x));
		rm[2][2] = one - 2 * (qprod(x, x) + qprod(y, y));
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) begin
				lm[i][c] = clamp32(floor_shr(floor_shr(rm[i][c], 14) * sc[c], 16));
			end
			lm[i][3] = clamp32(tr[i]);
		end
		// negative, self or later parent makes a root
		has_parent = !q.parent_index[8] && (int'(q.parent_index[7:0]) < idx);
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 4; c++) begin
				if (has_parent) begin
					acc = (c == 3) ? longint'(pose_rows[q.parent_index[7:0]*12 + i*4 + 3]) : 0;
					for (int k = 0; k < 3; k++) begin
						acc += floor_shr(
							longint'(pose_rows[q.parent_index[7:0]*12 + i*4 + k]) * lm[k][c], 16);
					end
					gm[i][c] = clamp32(acc);
				end else begin
					gm[i][c] = lm[i][c];
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 4; c++) begin
				pose_rows[idx*12 + i*4 + c] = gm[i][c][31:0];
			end
			r.joint_index = idx[7:0];
			r.row_index = i[1:0];
			r.col0 = gm[i][0][31:0];
			r.col1 = gm[i][1][31:0];
			r.col2 = gm[i][2][31:0];
			r.col3 = gm[i][3][31:0];
			r.last_row = (i == 2);
			row_queue.push_back(r);
		end
		joint_count = idx + 1;
	endtask

	function automatic joint_req_t make_req(bit first, int parent,
			logic [31:0] t, logic [31:0] qw, logic [31:0] qv, logic [31:0] s);
		joint_req_t q;
		q.first_joint = first;
		q.parent_index = parent[8:0];
		q.trans_x = t; q.trans_y = t; q.trans_z = t;
		q.rot_w = qw; q.rot_x = qv; q.rot_y = qv; q.rot_z = qv;
		q.scale_x = s; q.scale_y = s; q.scale_z = s;
		return q;
	endfunction

	function automatic joint_req_t rand_req(bit first);
		joint_req_t q;
		int mode;
		q = '0;
		q.first_joint = first;
		mode = $urandom_range(0, 9);
		// mostly a plausible parent; sometimes self, later or negative
		if (mode < 7 && joint_count > 0 && !first) begin
			q.parent_index = 9'($urandom_range(0, joint_count - 1));
		end else if (mode == 7) begin
			q.parent_index = 9'(-int'($urandom_range(1, 256)));
		end else begin
			q.parent_index = 9'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 3) == 0) begin
			// full-range noise in every field
			{q.trans_x, q.trans_y, q.trans_z} = {$urandom, $urandom, $urandom};
			{q.rot_w, q.rot_x, q.rot_y, q.rot_z} = {$urandom, $urandom, $urandom, $urandom};
			{q.scale_x, q.scale_y, q.scale_z} = {$urandom, $urandom, $urandom};
		end else begin
			q.trans_x = 32'($signed($urandom) >>> $urandom_range(4, 16));
			q.trans_y = 32'($signed($urandom) >>> $urandom_range(4, 16));
			q.trans_z = 32'($signed($urandom) >>> $urandom_range(4, 16));
			q.rot_w = 32'($signed($urandom) >>> 2);
			q.rot_x = 32'($signed($urandom) >>> 2);
			q.rot_y = 32'($signed($urandom) >>> 2);
			q.rot_z = 32'($signed($urandom) >>> 2);
			q.scale_x = 32'($signed($urandom) >>> $urandom_range(12, 15));
			q.scale_y = 32'($signed($urandom) >>> $urandom_range(12, 15));
			q.scale_z = 32'($signed($urandom) >>> $urandom_range(12, 15));
		end
		return q;
	endfunction

	// offer one request and wait for acceptance, then predict its rows
	task automatic send_req(input joint_req_t q);
		s_tdata <= InDataW'({q.scale_z, q.scale_y, q.scale_x, q.rot_z, q.rot_y, q.rot_x,
			q.rot_w, q.trans_z, q.trans_y, q.trans_x, q.parent_index});
		s_tuser <= q.first_joint;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predict_joint(q);
	endtask

	int burst_left;

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left = $urandom_range(0, 8);
	endtask

	// directed stimulus
	dir_row_t dir_tab[$];
	row_res_t typed_rows[$];

	initial begin
		dir_row_t d;
		joint_req_t q;
		int pose_len;
		int left;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		stim_done = 1'b0;
		burst_left = 0;
		joint_count = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity root: rows of the unit matrix with translation
		d.typed = 1'b1;
		d.req = make_req(1'b1, -1, 32'sh0003_0000, QOne, 32'sh0, FxOne);
		d.row0 = '{8'd0, 2'd0, FxOne, 32'sh0, 32'sh0, 32'sh0003_0000, 1'b0};
		dir_tab.push_back(d);
		// zero scale, zero rotation elements off the diagonal
		d.req = make_req(1'b0, -1, SMin, QOne, 32'sh0, 32'sh0);
		d.row0 = '{8'd1, 2'd0, 32'sh0, 32'sh0, 32'sh0, SMin, 1'b0};
		dir_tab.push_back(d);
		// huge scale drives the diagonal to the maximum
		d.req = make_req(1'b0, 300, SMax, QOne, 32'sh0, SMax);
		d.row0 = '{8'd2, 2'd0, SMax, 32'sh0, 32'sh0, SMax, 1'b0};
		dir_tab.push_back(d);
		d.typed = 1'b0;
		// children of the above; self, later and negative parents are roots
		dir_tab.push_back('{make_req(1'b0, 0, 32'sh1234_5678, QOne, 32'sh0, FxOne), 0, '0});
		dir_tab.push_back('{make_req(1'b0, 2, SMin, SMin, SMin, SMin), 0, '0});
		dir_tab.push_back('{make_req(1'b0, 5, SMax, SMax, SMax, SMax), 0, '0});
		dir_tab.push_back('{make_req(1'b0, 9, 32'h0, SMin, SMax, SMax), 0, '0});
		dir_tab.push_back('{make_req(1'b0, 255, 32'hffff_ffff, 32'h0, QOne, SMin), 0, '0});
		dir_tab.push_back('{make_req(1'b0, 4, SMax, SMax, SMin, SMax), 0, '0});
		dir_tab.push_back('{make_req(1'b0, -256, 32'h5555_5555, 32'haaaa_aaaa,
			32'h5555_5555, 32'haaaa_aaaa), 0, '0});
		dir_tab.push_back('{make_req(1'b0, 3, 32'haaaa_aaaa, 32'h2d41_3ccd,
			32'h2d41_3ccd, 32'h0002_0000), 0, '0});
		dir_tab.push_back('{make_req(1'b1, 0, 32'h7, QOne, 32'h0, FxOne), 0, '0});
		foreach (dir_tab[i]) begin
			if (dir_tab[i].typed) begin
				typed_rows.push_back(dir_tab[i].row0);
			end
			pace_sender();
			send_req(dir_tab[i].req);
		end

		// fill a pose past capacity, so the extra joints are dropped
		for (int i = 0; i < NumJoints + 6; i++) begin
			pace_sender();
			send_req(rand_req(i == 0));
		end

		// random poses of random length, with a few broken ones
		left = RandItems;
		while (left > 0) begin
			pose_len = $urandom_range(1, 24);
			for (int j = 0; j < pose_len && left > 0; j++) begin
				q = rand_req(j == 0 ? 1'b1 : ($urandom_range(0, 40) == 0));
				pace_sender();
				send_req(q);
				left--;
			end
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stall pattern, one long hold-off after the start
	initial begin
		hold_long = 1'b0;
		@(posedge arst_n);
		repeat (400) @(posedge clk);
		hold_long <= 1'b1;
		repeat (1500) @(posedge clk);
		hold_long <= 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_long) begin
			m_tready <= 1'b0;
		end else begin
			case ($urandom_range(0, 7))
				0, 1: m_tready <= 1'b0;
				default: m_tready <= 1'b1;
			endcase
		end
	end

	// compare accepted rows with the oldest prediction
	always @(posedge clk) begin
		row_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.joint_index = m_tdata[7:0];
			got.row_index = m_tdata[9:8];
			got.col0 = m_tdata[41:10];
			got.col1 = m_tdata[73:42];
			got.col2 = m_tdata[105:74];
			got.col3 = m_tdata[137:106];
			got.last_row = m_tlast;
			if (row_queue.size() == 0) begin
				unmatched++;
				if (mismatches + unmatched <= 10) begin
					$display("unexpected row %p", got);
				end
			end else begin
				want = row_queue.pop_front();
				if (want.row_index == 0 && typed_rows.size() > 0
						&& want.joint_index == typed_rows[0].joint_index) begin
					// hand-typed rows must agree with the emitted row as well
					if (typed_rows[0] != got) begin
						mismatches++;
						if (mismatches + unmatched <= 10) begin
							$display("typed row: expected %p got %p", typed_rows[0], got);
						end
					end
					void'(typed_rows.pop_front());
				end
				if (want != got) begin
					mismatches++;
					if (mismatches + unmatched <= 10) begin
						$display("row mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

	// end of run
	initial begin
		mismatches = 0;
		unmatched = 0;
		wait (stim_done);
		while (row_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && unmatched == 0 && typed_rows.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### joint_global_transform_core.f
hw/rtl/jgt_pkg.sv
hw/rtl/joint_global_transform_core.sv
tb/sv/tb_top.sv
